FILE: sv/lsbc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lsbc_pkg
// Shared widths, constants and inter-cell types of the LFU sector buffer cache.
// ----------------------------------------------------------------------------
package lsbc_pkg;

	localparam int SECTOR_W        = 32;
	localparam int COUNT_W         = 8;
	localparam int USE_W           = 16;
	localparam int SLOT_W          = 4;
	localparam int IDX_W           = 6;
	localparam int NUM_ENTRIES_DEF = 16;
	localparam int NUM_ENTRIES_MAX = 64;

	localparam logic [USE_W-1:0] USE_MAX = {USE_W{1'b1}};
	localparam logic [USE_W-1:0] USE_ONE = USE_W'(1);

	// search token handed from cell to cell
	typedef struct packed {
		logic               valid;
		logic               found;
		logic               full;
		logic [IDX_W-1:0]   idx;
		logic [USE_W:0]     best_use;
	} carry_t;

	// directory update broadcast to all cells
	typedef struct packed {
		logic               valid;
		logic               hit;
		logic               full;
		logic [IDX_W-1:0]   idx;
	} update_t;

endpackage

`default_nettype wire

FILE: sv/lsbc_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lsbc_cell
// One directory entry: tag, use counter and span, plus one stage of the
// tag/least-use search token.
// ----------------------------------------------------------------------------
module lsbc_cell #(
	parameter int IDX = 0
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire  [lsbc_pkg::SECTOR_W-1:0]    sector,
	input  wire  [lsbc_pkg::COUNT_W-1:0]     count,
	input  lsbc_pkg::carry_t                 carry_i,
	output lsbc_pkg::carry_t                 carry_o,
	input  lsbc_pkg::update_t                upd
);

	logic [lsbc_pkg::SECTOR_W-1:0] tag_q;
	logic [lsbc_pkg::USE_W-1:0]    use_q;
	logic [lsbc_pkg::COUNT_W-1:0]  span_q;
	lsbc_pkg::carry_t              carry_q;
	lsbc_pkg::carry_t              carry_d;
	logic                          mine;

	localparam logic [lsbc_pkg::IDX_W-1:0] MY_IDX = lsbc_pkg::IDX_W'(IDX);

	always_comb begin
		carry_d = carry_i;
		if (!carry_i.found) begin
			if (tag_q == sector) begin
				carry_d.found = 1'b1;
				carry_d.idx   = MY_IDX;
				carry_d.full  = (span_q >= count);
			end else if ({1'b0, use_q} < carry_i.best_use) begin
				carry_d.idx      = MY_IDX;
				carry_d.best_use = {1'b0, use_q};
			end
		end
	end

	assign mine    = upd.valid && (upd.idx == MY_IDX);
	assign carry_o = carry_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			carry_q <= '0;
		end else begin
			carry_q <= carry_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_q  <= '0;
			use_q  <= '0;
			span_q <= '0;
		end else if (mine) begin
			if (upd.hit) begin
				if (use_q != lsbc_pkg::USE_MAX) begin
					use_q <= use_q + lsbc_pkg::USE_ONE;
				end
				if (!upd.full) begin
					span_q <= count;
				end
			end else begin
				tag_q  <= sector;
				use_q  <= lsbc_pkg::USE_ONE;
				span_q <= count;
			end
		end
	end

endmodule

`default_nettype wire

FILE: sv/lfu_sector_buffer_cache.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lfu_sector_buffer_cache
// LFU buffer-cache directory built as a row of entry cells that a search
// token walks through, one cell per cycle, followed by an update of one entry.
// ----------------------------------------------------------------------------
// The accepted item is registered into inj_q, then the token walks the cell
//   chain one entry per cycle and done is registered from the update. busy
//   is high from accept to strobe, and no new item is accepted meanwhile.
// Reset: arst_n clears all tags, use counters and spans to zero and idles.
// The receiver cannot stall: done is high for a single cycle; slot_index and must_load hold until the next update.
module lfu_sector_buffer_cache #(
	parameter int NUM_ENTRIES = lsbc_pkg::NUM_ENTRIES_DEF
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              start,
	output logic                             busy,
	input  wire  [lsbc_pkg::SECTOR_W-1:0]    sector_number,
	input  wire  [lsbc_pkg::COUNT_W-1:0]     sector_count,
	output logic                             done,
	output logic [lsbc_pkg::SLOT_W-1:0]      slot_index,
	output logic                             must_load
);

	logic [lsbc_pkg::SECTOR_W-1:0] sector_q;
	logic [lsbc_pkg::COUNT_W-1:0]  count_q;
	logic                          busy_q;
	logic                          inj_q;
	logic                          done_q;
	logic [lsbc_pkg::SLOT_W-1:0]   slot_q;
	logic                          load_q;
	logic                          accept;
	lsbc_pkg::carry_t              chain [NUM_ENTRIES+1];
	lsbc_pkg::update_t             upd;
	logic [NUM_ENTRIES:0]          tok_valid;

	assign accept = start && !busy_q;

	always_comb begin
		chain[0]          = '0;
		chain[0].valid    = inj_q;
		chain[0].best_use = '1;
	end

	for (genvar k = 0; k < NUM_ENTRIES; k++) begin : g_cell
		lsbc_cell #(
			.IDX(k)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.sector (sector_q),
			.count  (count_q),
			.carry_i(chain[k]),
			.carry_o(chain[k+1]),
			.upd    (upd)
		);
	end

	for (genvar k = 0; k <= NUM_ENTRIES; k++) begin : g_tok
		assign tok_valid[k] = chain[k].valid;
	end

	always_comb begin
		upd.valid = chain[NUM_ENTRIES].valid;
		upd.hit   = chain[NUM_ENTRIES].found;
		upd.full  = chain[NUM_ENTRIES].full;
		upd.idx   = chain[NUM_ENTRIES].idx;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sector_q <= sector_number;
			count_q  <= sector_count;
		end
		if (upd.valid) begin
			slot_q <= lsbc_pkg::SLOT_W'(upd.idx);
			load_q <= !(upd.hit && upd.full);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			inj_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			inj_q  <= accept;
			done_q <= upd.valid;
			if (accept) begin
				busy_q <= 1'b1;
			end else if (upd.valid) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign busy       = busy_q;
	assign done       = done_q;
	assign slot_index = slot_q;
	assign must_load  = load_q;

`ifndef SYNTHESIS
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tok_valid))
		else $error("more than one search token in the cell chain");

	a_token_only_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(tok_valid != '0) |-> busy_q)
		else $error("search token moving while idle");

	a_done_ends_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (!busy_q && $past(busy_q)))
		else $error("done strobe without a finished item");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (busy_q && chain[0].valid))
		else $error("accepted item did not enter the chain");
`endif

endmodule

`default_nettype wire
